// ===== rtl/svpwm_pkg.sv =====
// Shared types, constants and codes for the space vector PWM duty block.
package svpwm_pkg;

    localparam int VOLT_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int SECTOR_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int SQRT3_W     = 17;
    localparam int SCALE_SHIFT = 33;

    // sqrt(3) in Q1.16
    localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

    localparam logic [VOLT_W-1:0]  BUS_VOLTAGE_RST = 16'd24576;
    localparam logic [COUNT_W-1:0] PWM_PERIOD_RST  = 16'd1000;
    localparam logic [COUNT_W-1:0] DUTY_LIMIT_RST  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_VOLTAGE = 2'd0,
        CFG_PWM_PERIOD  = 2'd1,
        CFG_DUTY_LIMIT  = 2'd2
    } cfg_index_t;

    typedef enum logic [SECTOR_W-1:0] {
        SECTOR_NONE = 3'd0,
        SECTOR_1    = 3'd1,
        SECTOR_2    = 3'd2,
        SECTOR_3    = 3'd3,
        SECTOR_4    = 3'd4,
        SECTOR_5    = 3'd5,
        SECTOR_6    = 3'd6,
        SECTOR_ALL  = 3'd7
    } sector_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] volt_alpha;
        logic signed [VOLT_W-1:0] volt_beta;
    } vec_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  duty_phase_a;
        logic [COUNT_W-1:0]  duty_phase_b;
        logic [COUNT_W-1:0]  duty_phase_c;
        logic [SECTOR_W-1:0] sector_code;
    } duty_word_t;

endpackage

// ===== rtl/svpwm_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module svpwm_div #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_side,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem_a,
    input  logic [DW-1:0] rem_b,
    input  logic [QW-1:0] lo_a,
    input  logic [QW-1:0] lo_b,
    output logic          out_valid,
    output logic [SW-1:0] out_side,
    output logic [QW-1:0] quo_a,
    output logic [QW-1:0] quo_b
);

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [DW:0] div_step(
        input logic [DW-1:0] rem,
        input logic          bit_in,
        input logic [DW-1:0] dv
    );
        logic [DW:0] r2;
        logic [DW:0] d2;
        r2 = {rem, bit_in};
        d2 = r2 - {1'b0, dv};
        if (r2 >= {1'b0, dv})
            div_step = {1'b1, d2[DW-1:0]};
        else
            div_step = {1'b0, r2[DW-1:0]};
    endfunction

    logic          valid_reg [QW];
    logic [SW-1:0] side_reg  [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [DW-1:0] rem_a_reg [QW];
    logic [DW-1:0] rem_b_reg [QW];
    logic [QW-1:0] sh_a_reg  [QW];
    logic [QW-1:0] sh_b_reg  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          v_in;
        logic [SW-1:0] side_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] ra_in;
        logic [DW-1:0] rb_in;
        logic [QW-1:0] sa_in;
        logic [QW-1:0] sb_in;
        logic [DW:0]   res_a;
        logic [DW:0]   res_b;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign den_in  = den;
            assign ra_in   = rem_a;
            assign rb_in   = rem_b;
            assign sa_in   = lo_a;
            assign sb_in   = lo_b;
        end
        else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign side_in = side_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign ra_in   = rem_a_reg[s-1];
            assign rb_in   = rem_b_reg[s-1];
            assign sa_in   = sh_a_reg[s-1];
            assign sb_in   = sh_b_reg[s-1];
        end

        assign res_a = div_step(ra_in, sa_in[QW-1], den_in);
        assign res_b = div_step(rb_in, sb_in[QW-1], den_in);

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= v_in;
        end

        // Shift one dividend bit out and one quotient bit in
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s]  <= side_in;
                den_reg[s]   <= den_in;
                rem_a_reg[s] <= res_a[DW-1:0];
                rem_b_reg[s] <= res_b[DW-1:0];
                sh_a_reg[s]  <= {sa_in[QW-2:0], res_a[DW]};
                sh_b_reg[s]  <= {sb_in[QW-2:0], res_b[DW]};
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign quo_a     = sh_a_reg[QW-1];
    assign quo_b     = sh_b_reg[QW-1];

endmodule

// ===== rtl/space_vector_pwm_duty_top.sv =====
// Space vector PWM duty generator: top level with register file and pipeline.
//
// Usage:
//   vec channel (vec_valid / vec_stall / vec_data) takes one alpha/beta
//   voltage word per cycle unless stalled. duty channel (duty_valid /
//   duty_stall / duty_data) returns the three inverted, clamped compare
//   values and the sector code, one result word per input word, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   bus_voltage, pwm_period and duty_limit; cfg_ready is always high.
//   Write registers only while no word is in flight.
// Pipeline:
//   5 stages of projection and scaling multiplies, 33 stages of the
//   bus voltage divider (one quotient bit each), one stage of rescale
//   products, 16 stages of the rescale divider and three stages of
//   on-time and duty math. Throughput is one word per cycle unless stalled.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults. When the
//   output word is held by duty_stall, the whole pipeline freezes and
//   vec_stall rises in the same cycle; nothing is lost or repeated.
module space_vector_pwm_duty_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vec_valid,
    output logic                                vec_stall,
    input  svpwm_pkg::vec_word_t                vec_data,
    output logic                                duty_valid,
    input  logic                                duty_stall,
    output svpwm_pkg::duty_word_t               duty_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svpwm_pkg::COUNT_W-1:0]       cfg_data
);

    import svpwm_pkg::*;

    localparam int PROJ_W = VOLT_W + 18;
    localparam int MAG_W  = VOLT_W + 17;
    localparam int NUM_W  = MAG_W + SQRT3_W;
    localparam int HI_W   = NUM_W - SCALE_SHIFT;
    localparam int TIME_W = HI_W + COUNT_W;
    localparam int SUM_W  = TIME_W + 1;
    localparam int PROD_W = TIME_W + COUNT_W;
    localparam int LOP_W  = SCALE_SHIFT + COUNT_W;
    localparam int SIDE_W = SECTOR_W + 1 + 2 * COUNT_W;

    localparam logic signed [SQRT3_W:0] SQRT3_S = {1'b0, SQRT3_Q16};

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                resc;
        logic [COUNT_W-1:0]  q1;
        logic [COUNT_W-1:0]  q2;
    } resc_side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [VOLT_W-1:0]  bus_voltage_reg;
    logic [COUNT_W-1:0] pwm_period_reg;
    logic [COUNT_W-1:0] duty_limit_reg;

    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg <= BUS_VOLTAGE_RST;
            pwm_period_reg  <= PWM_PERIOD_RST;
            duty_limit_reg  <= DUTY_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BUS_VOLTAGE: bus_voltage_reg <= cfg_data;
                CFG_PWM_PERIOD:  pwm_period_reg  <= cfg_data;
                CFG_DUTY_LIMIT:  duty_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: freeze everything while the output word is held
    logic en;
    logic duty_valid_reg;

    assign en        = !(duty_valid_reg && duty_stall);
    assign vec_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: exact projections in 2^-27 V
    logic                     s1_valid_reg;
    logic signed [PROJ_W-1:0] s1_u2a_reg, s1_u2b_reg, s1_u2c_reg;
    logic signed [PROJ_W-1:0] a_sq, b_16, b_17;

    assign a_sq = PROJ_W'(vec_data.volt_alpha * SQRT3_S);
    assign b_16 = PROJ_W'(vec_data.volt_beta) <<< 16;
    assign b_17 = PROJ_W'(vec_data.volt_beta) <<< 17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= vec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u2a_reg <= b_17;
            s1_u2b_reg <= a_sq - b_16;
            s1_u2c_reg <= -a_sq - b_16;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sector code and magnitudes of the two active projections
    logic               s2_valid_reg;
    sector_t            s2_sector_reg;
    logic [MAG_W-1:0]   s2_mag1_reg, s2_mag2_reg;
    logic               pos_a, pos_b, pos_c;
    sector_t            sector_next;
    logic [PROJ_W-1:0]  abs_a, abs_b, abs_c;
    logic [MAG_W-1:0]   mag_a, mag_b, mag_c;
    logic [MAG_W-1:0]   mag1_next, mag2_next;

    assign pos_a = !s1_u2a_reg[PROJ_W-1] && (s1_u2a_reg != '0);
    assign pos_b = !s1_u2b_reg[PROJ_W-1] && (s1_u2b_reg != '0);
    assign pos_c = !s1_u2c_reg[PROJ_W-1] && (s1_u2c_reg != '0);
    assign sector_next = sector_t'({pos_c, pos_b, pos_a});

    assign abs_a = s1_u2a_reg[PROJ_W-1] ? -s1_u2a_reg : s1_u2a_reg;
    assign abs_b = s1_u2b_reg[PROJ_W-1] ? -s1_u2b_reg : s1_u2b_reg;
    assign abs_c = s1_u2c_reg[PROJ_W-1] ? -s1_u2c_reg : s1_u2c_reg;
    assign mag_a = abs_a[MAG_W-1:0];
    assign mag_b = abs_b[MAG_W-1:0];
    assign mag_c = abs_c[MAG_W-1:0];

    // Pick the two projections that set the active-vector times
    always_comb
    begin
        case (sector_next)
            SECTOR_1: begin mag1_next = mag_b; mag2_next = mag_c; end
            SECTOR_2: begin mag1_next = mag_c; mag2_next = mag_a; end
            SECTOR_3: begin mag1_next = mag_b; mag2_next = mag_a; end
            SECTOR_4: begin mag1_next = mag_a; mag2_next = mag_b; end
            SECTOR_5: begin mag1_next = mag_a; mag2_next = mag_c; end
            SECTOR_6: begin mag1_next = mag_c; mag2_next = mag_b; end
            default:  begin mag1_next = '0;    mag2_next = '0;    end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sector_reg <= sector_next;
            s2_mag1_reg   <= mag1_next;
            s2_mag2_reg   <= mag2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale by sqrt3
    logic             s3_valid_reg;
    sector_t          s3_sector_reg;
    logic [NUM_W-1:0] s3_num1_reg, s3_num2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_num1_reg   <= NUM_W'(s2_mag1_reg) * NUM_W'(SQRT3_Q16);
            s3_num2_reg   <= NUM_W'(s2_mag2_reg) * NUM_W'(SQRT3_Q16);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: multiply high and low halves by the period
    logic                    s4_valid_reg;
    sector_t                 s4_sector_reg;
    logic [HI_W+COUNT_W-1:0] s4_hp1_reg, s4_hp2_reg;
    logic [LOP_W-1:0]        s4_lp1_reg, s4_lp2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_hp1_reg <= (HI_W+COUNT_W)'(s3_num1_reg[NUM_W-1:SCALE_SHIFT])
                          * (HI_W+COUNT_W)'(pwm_period_reg);
            s4_hp2_reg <= (HI_W+COUNT_W)'(s3_num2_reg[NUM_W-1:SCALE_SHIFT])
                          * (HI_W+COUNT_W)'(pwm_period_reg);
            s4_lp1_reg <= LOP_W'(s3_num1_reg[SCALE_SHIFT-1:0]) * LOP_W'(pwm_period_reg);
            s4_lp2_reg <= LOP_W'(s3_num2_reg[SCALE_SHIFT-1:0]) * LOP_W'(pwm_period_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine into floor(num * period / 2^33)
    logic              s5_valid_reg;
    sector_t           s5_sector_reg;
    logic [TIME_W-1:0] s5_t1_reg, s5_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_sector_reg <= s4_sector_reg;
            s5_t1_reg <= s4_hp1_reg + TIME_W'(s4_lp1_reg[LOP_W-1:SCALE_SHIFT]);
            s5_t2_reg <= s4_hp2_reg + TIME_W'(s4_lp2_reg[LOP_W-1:SCALE_SHIFT]);
        end
    end

    // ------------------------------------------------------------------
    // Divide by the bus voltage (zero counts as one)
    logic [VOLT_W-1:0]   bus_eff;
    logic                d1_valid;
    logic [SECTOR_W-1:0] d1_side;
    logic [TIME_W-1:0]   d1_q1, d1_q2;

    assign bus_eff = (bus_voltage_reg == '0) ? VOLT_W'(1) : bus_voltage_reg;

    svpwm_div #(
        .DW (VOLT_W),
        .QW (TIME_W),
        .SW (SECTOR_W)
    ) u_bus_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_side   (s5_sector_reg),
        .den       (bus_eff),
        .rem_a     ('0),
        .rem_b     ('0),
        .lo_a      (s5_t1_reg),
        .lo_b      (s5_t2_reg),
        .out_valid (d1_valid),
        .out_side  (d1_side),
        .quo_a     (d1_q1),
        .quo_b     (d1_q2)
    );

    // ------------------------------------------------------------------
    // Stage 6: sum, overflow test and rescale products
    logic              s6_valid_reg;
    resc_side_t        s6_side_reg;
    logic [SUM_W-1:0]  s6_sum_reg;
    logic [PROD_W-1:0] s6_p1_reg, s6_p2_reg;
    logic [SUM_W-1:0]  sum_next;

    assign sum_next = SUM_W'(d1_q1) + SUM_W'(d1_q2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (en)
            s6_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg.sector <= d1_side;
            s6_side_reg.resc   <= sum_next > SUM_W'(pwm_period_reg);
            s6_side_reg.q1     <= d1_q1[COUNT_W-1:0];
            s6_side_reg.q2     <= d1_q2[COUNT_W-1:0];
            s6_sum_reg         <= sum_next;
            s6_p1_reg          <= PROD_W'(d1_q1) * PROD_W'(pwm_period_reg);
            s6_p2_reg          <= PROD_W'(d1_q2) * PROD_W'(pwm_period_reg);
        end
    end

    // ------------------------------------------------------------------
    // Rescale divider: t * period / sum
    logic               d2_valid;
    logic [SIDE_W-1:0]  d2_side_bits;
    resc_side_t         d2_side;
    logic [COUNT_W-1:0] d2_q1, d2_q2;

    svpwm_div #(
        .DW (SUM_W),
        .QW (COUNT_W),
        .SW (SIDE_W)
    ) u_resc_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_side   (s6_side_reg),
        .den       (s6_sum_reg),
        .rem_a     (SUM_W'(s6_p1_reg[PROD_W-1:COUNT_W])),
        .rem_b     (SUM_W'(s6_p2_reg[PROD_W-1:COUNT_W])),
        .lo_a      (s6_p1_reg[COUNT_W-1:0]),
        .lo_b      (s6_p2_reg[COUNT_W-1:0]),
        .out_valid (d2_valid),
        .out_side  (d2_side_bits),
        .quo_a     (d2_q1),
        .quo_b     (d2_q2)
    );

    assign d2_side = resc_side_t'(d2_side_bits);

    // ------------------------------------------------------------------
    // Stage 7: pick rescaled or direct times
    logic               s7_valid_reg;
    sector_t            s7_sector_reg;
    logic [COUNT_W-1:0] s7_t1_reg, s7_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (en)
            s7_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_sector_reg <= sector_t'(d2_side.sector);
            s7_t1_reg     <= d2_side.resc ? d2_q1 : d2_side.q1;
            s7_t2_reg     <= d2_side.resc ? d2_q2 : d2_side.q2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: phase on-times
    logic               s8_valid_reg;
    sector_t            s8_sector_reg;
    logic               s8_zero_reg;
    logic [COUNT_W-1:0] s8_on_a_reg, s8_on_b_reg, s8_on_c_reg;
    logic [COUNT_W:0]   rest, base_w, mid_w, top_w;
    logic [COUNT_W-1:0] base, mid, top;
    logic [COUNT_W-1:0] on_a_next, on_b_next, on_c_next;

    assign rest   = {1'b0, pwm_period_reg} - {1'b0, s7_t1_reg} - {1'b0, s7_t2_reg};
    assign base_w = rest >> 2;
    assign mid_w  = base_w + {2'b0, s7_t1_reg[COUNT_W-1:1]};
    assign top_w  = mid_w + {2'b0, s7_t2_reg[COUNT_W-1:1]};
    assign base   = base_w[COUNT_W-1:0];
    assign mid    = mid_w[COUNT_W-1:0];
    assign top    = top_w[COUNT_W-1:0];

    // Route base/mid/top to the phases for this sector
    always_comb
    begin
        case (s7_sector_reg)
            SECTOR_1: begin on_b_next = base; on_a_next = mid; on_c_next = top; end
            SECTOR_2: begin on_a_next = base; on_c_next = mid; on_b_next = top; end
            SECTOR_3: begin on_a_next = base; on_b_next = mid; on_c_next = top; end
            SECTOR_4: begin on_c_next = base; on_b_next = mid; on_a_next = top; end
            SECTOR_5: begin on_b_next = base; on_c_next = mid; on_a_next = top; end
            SECTOR_6: begin on_c_next = base; on_a_next = mid; on_b_next = top; end
            default:  begin on_a_next = '0;   on_b_next = '0;  on_c_next = '0;  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (en)
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_sector_reg <= s7_sector_reg;
            s8_zero_reg   <= (s7_t1_reg == '0) && (s7_t2_reg == '0);
            s8_on_a_reg   <= on_a_next;
            s8_on_b_reg   <= on_b_next;
            s8_on_c_reg   <= on_c_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: invert, clamp and hold the output word
    duty_word_t         duty_data_reg;
    logic [COUNT_W-1:0] inv_a, inv_b, inv_c;

    assign inv_a = s8_zero_reg ? '0 : pwm_period_reg - s8_on_a_reg;
    assign inv_b = s8_zero_reg ? '0 : pwm_period_reg - s8_on_b_reg;
    assign inv_c = s8_zero_reg ? '0 : pwm_period_reg - s8_on_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_valid_reg <= 1'b0;
        else if (en)
            duty_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            duty_data_reg.duty_phase_a <= (inv_a > duty_limit_reg) ? duty_limit_reg : inv_a;
            duty_data_reg.duty_phase_b <= (inv_b > duty_limit_reg) ? duty_limit_reg : inv_b;
            duty_data_reg.duty_phase_c <= (inv_c > duty_limit_reg) ? duty_limit_reg : inv_c;
            duty_data_reg.sector_code  <= s8_sector_reg;
        end
    end

    assign duty_valid = duty_valid_reg;
    assign duty_data  = duty_data_reg;

`ifndef SYNTHESIS
    // The three projections sum to zero, so all-positive never appears
    a_no_full_sector: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> (duty_data.sector_code != SECTOR_ALL))
        else $error("sector code with all projections positive");

    // A zero vector gives zero duty on every phase
    a_zero_sector_idle: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && (duty_data.sector_code == SECTOR_NONE) |->
        (duty_data.duty_phase_a == '0) && (duty_data.duty_phase_b == '0) &&
        (duty_data.duty_phase_c == '0))
        else $error("nonzero duty for zero sector");

    // Every delivered duty respects the clamp
    a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> (duty_data.duty_phase_a <= duty_limit_reg) &&
        (duty_data.duty_phase_b <= duty_limit_reg) &&
        (duty_data.duty_phase_c <= duty_limit_reg))
        else $error("duty above limit");

    // A held output word stays on the port across a stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && duty_stall |=> duty_valid && $stable(duty_data))
        else $error("output word changed while stalled");
`endif

endmodule
